/* sv/mio_pkg.sv */
// Package for the maximum interval overlap block: sizes, word types, state codes.
// No dependencies.
package mio_pkg;

  localparam int unsigned MaxItems  = 1024;
  localparam int unsigned TimeWidth = 32;
  localparam int unsigned AddrWidth = $clog2(MaxItems);
  localparam int unsigned CntWidth  = AddrWidth + 1;
  localparam int unsigned ResWidth  = 11;

  typedef struct packed {
    logic [31:0] arrival_time;
    logic [31:0] leave_time;
    logic        last_item;
  } mio_in_t;

  typedef struct packed {
    logic [ResWidth-1:0] max_present;
    logic                overflow;
  } mio_out_t;

  typedef enum logic [2:0] {
    StIdle,
    StOuterRd,
    StOuterLatch,
    StInner,
    StInnerLast,
    StEval,
    StDone
  } mio_state_e;

  typedef struct packed {
    logic load;
    logic clear;
    logic outer_rd;
    logic outer_latch;
    logic inner_rd;
    logic inner_acc;
    logic eval;
    logic done;
  } mio_cmd_t;

  typedef struct packed {
    logic empty;
    logic outer_end;
    logic inner_end;
  } mio_sts_t;

endpackage

/* sv/mio_ram.sv */
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module mio_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* sv/mio_ctrl.sv */
// Controller for the overlap block: load, then nested compare sweep.
// Depends on mio_pkg.
module mio_ctrl import mio_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     last_i,
  input  mio_sts_t sts_i,
  output logic     busy_o,
  output mio_cmd_t cmd_o
);

  mio_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start_i && last_i) begin
          state_d = StOuterRd;
        end
      end
      StOuterRd: begin
        state_d = sts_i.empty ? StDone : StOuterLatch;
      end
      StOuterLatch: state_d = sts_i.inner_end ? StInnerLast : StInner;
      StInner: begin
        if (sts_i.inner_end) begin
          state_d = StInnerLast;
        end
      end
      StInnerLast: state_d = StEval;
      StEval: state_d = sts_i.outer_end ? StDone : StOuterRd;
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = (state_q != StIdle);
    case (state_q)
      StIdle: begin
        cmd_o.load = start_i;
      end
      StOuterRd:    cmd_o.outer_rd = 1'b1;
      StOuterLatch: begin
        cmd_o.outer_latch = 1'b1;
        cmd_o.inner_rd    = 1'b1;
      end
      StInner: begin
        cmd_o.inner_rd  = 1'b1;
        cmd_o.inner_acc = 1'b1;
      end
      StInnerLast:  cmd_o.inner_acc = 1'b1;
      StEval:       cmd_o.eval = 1'b1;
      StDone: begin
        cmd_o.done  = 1'b1;
        cmd_o.clear = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

/* sv/mio_dp.sv */
// Datapath: interval stores, counters, compare accumulators and peak register.
// Depends on mio_pkg and mio_ram.
module mio_dp import mio_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mio_cmd_t cmd_i,
  input  mio_in_t  in_i,
  output mio_sts_t sts_o,
  output mio_out_t res_o
);

  logic [CntWidth-1:0]  count_q, count_d;
  logic                 ovf_q, ovf_d;
  logic [AddrWidth-1:0] oidx_q, iidx_q;
  logic [CntWidth-1:0]  started_q, left_q;
  logic [CntWidth-1:0]  best_q;
  logic [TimeWidth-1:0] pivot_q;
  logic [TimeWidth-1:0] arr_rd, lev_rd;
  logic [AddrWidth-1:0] raddr;
  logic                 full, we;

  assign full = (count_q == CntWidth'(MaxItems));
  assign we   = cmd_i.load && !full;
  assign raddr = cmd_i.outer_rd ? oidx_q : iidx_q;

  mio_ram #(.Width(TimeWidth), .Depth(MaxItems)) u_arr (
    .clk_i, .we_i(we), .waddr_i(count_q[AddrWidth-1:0]),
    .wdata_i(in_i.arrival_time[TimeWidth-1:0]), .raddr_i(raddr), .rdata_o(arr_rd)
  );
  mio_ram #(.Width(TimeWidth), .Depth(MaxItems)) u_lev (
    .clk_i, .we_i(we), .waddr_i(count_q[AddrWidth-1:0]),
    .wdata_i(in_i.leave_time[TimeWidth-1:0]), .raddr_i(raddr), .rdata_o(lev_rd)
  );

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (cmd_i.load) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + 1'b1;
      end
    end
    if (cmd_i.clear) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end
  end

  assign sts_o.empty     = (count_q == '0);
  assign sts_o.outer_end = ({1'b0, oidx_q} == count_q - 1'b1);
  assign sts_o.inner_end = ({1'b0, iidx_q} == count_q - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      oidx_q  <= '0;
      iidx_q  <= '0;
      best_q  <= '0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      if (cmd_i.outer_rd) begin
        iidx_q <= '0;
      end else if (cmd_i.inner_rd && !sts_o.inner_end) begin
        iidx_q <= iidx_q + 1'b1;
      end
      if (cmd_i.eval) begin
        oidx_q <= oidx_q + 1'b1;
        if (started_q > left_q && (started_q - left_q) > best_q) begin
          best_q <= started_q - left_q;
        end
      end
      if (cmd_i.clear) begin
        oidx_q <= '0;
      end
      if (cmd_i.load && in_i.last_item) begin
        best_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.outer_latch) begin
      pivot_q   <= arr_rd;
      started_q <= '0;
      left_q    <= '0;
    end else if (cmd_i.inner_acc) begin
      started_q <= started_q + CntWidth'(arr_rd <= pivot_q);
      left_q    <= left_q + CntWidth'(lev_rd < pivot_q);
    end
  end

  assign res_o.max_present = ResWidth'(best_q);
  assign res_o.overflow    = ovf_q;

endmodule

/* sv/max_interval_overlap.sv */
// Top level of the maximum interval overlap block: controller plus datapath.
// Depends on mio_pkg, mio_ctrl, mio_dp.
//
// Intervals load one word per cycle while busy is low; the word with
// last_item set starts the sweep, during which busy is high. The sweep
// compares every stored arrival against all N stored entries through one
// read port per store: for each stored arrival the controller steps through
// outer read, outer latch, inner reads, last inner accumulate and evaluate
// state, and a done state ends the sweep. The result shows on result_o for
// one cycle with done_o high and cannot be stalled.
module max_interval_overlap import mio_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  mio_in_t  item_i,
  output logic     done_o,
  output mio_out_t result_o
);

  mio_cmd_t cmd;
  mio_sts_t sts;

  mio_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start && !busy), .last_i(item_i.last_item),
    .sts_i(sts), .busy_o(busy), .cmd_o(cmd)
  );

  mio_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .in_i(item_i), .sts_o(sts), .res_o(result_o)
  );

  assign done_o = cmd.done;

endmodule

/* sv/mio_checker.sv */
// Port-level checker for max_interval_overlap, bound to the top level.
// Depends on mio_pkg.
module mio_checker import mio_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input mio_in_t  item_i,
  input logic     done_o,
  input mio_out_t result_o
);

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.last_item |=> busy) else $error("no sweep after last");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("done outside sweep");
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("busy after done");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> result_o.max_present <= ResWidth'(MaxItems)) else $error("count range");

endmodule

bind max_interval_overlap mio_checker u_chk (.*);
